// ===== rtl/bptc_pkg.sv =====
// bptc_pkg: shared types, constants and helpers for the barometric compensation block.
// Used by bptc_div_cell, bptc_div_chain and baro_temp_pressure_compensation.
package bptc_pkg;

    localparam int DIV_CELLS = 64;

    typedef enum logic [1:0] {
        REG_TEMP_COEFFS = 2'd0,
        REG_PRES_A      = 2'd1,
        REG_PRES_B      = 2'd2,
        REG_PRES_NINE   = 2'd3
    } cfg_reg_t;

    localparam logic signed [32:0] FINE_OFFSET = 33'sd128000;
    localparam logic [20:0]        PRES_BASE   = 21'd1048576;
    localparam logic [63:0]        PRES_SCALE  = 64'd3125;
    localparam logic [63:0]        X1_BIAS     = 64'h0000_8000_0000_0000;

    typedef struct packed {
        logic [31:0] temp;
        logic [31:0] fine;
        logic [19:0] praw;
        logic        want;
        logic        dz;
        logic        neg;
    } side_t;

    typedef struct packed {
        logic        v;
        logic [63:0] rem;
        logic [63:0] num;
        logic [63:0] den;
        side_t       side;
    } div_bus_t;

    // low 64 bits of a 64-bit word times a 17-bit signed factor
    function automatic logic [63:0] mul_lo64(input logic [63:0] a, input logic [16:0] b);
        logic signed [80:0] p;
        p = $signed(a) * $signed(b);
        return p[63:0];
    endfunction

    // low 32 bits of a 32-bit word times a 16-bit signed factor
    function automatic logic [31:0] mul_lo32(input logic [31:0] a, input logic [15:0] b);
        logic signed [47:0] p;
        p = $signed(a) * $signed(b);
        return p[31:0];
    endfunction

endpackage

// ===== rtl/bptc_div_cell.sv =====
// bptc_div_cell: one restoring-division cell, resolves one quotient bit per transaction.
// Depends on bptc_pkg.
module bptc_div_cell
    import bptc_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     en,
    input  div_bus_t din,
    output div_bus_t dout
);

    div_bus_t   bus_reg;
    div_bus_t   bus_next;
    logic [64:0] trial;
    logic [64:0] diff;
    logic        ge;

    always_comb
    begin
        trial    = {din.rem, din.num[63]};
        diff     = trial - {1'b0, din.den};
        ge       = !diff[64];
        bus_next = din;
        bus_next.rem = ge ? diff[63:0] : trial[63:0];
        bus_next.num = {din.num[62:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bus_reg <= '0;
        end
        else if (en)
        begin
            bus_reg <= bus_next;
        end
    end

    assign dout = bus_reg;

endmodule

// ===== rtl/bptc_div_chain.sv =====
// bptc_div_chain: row of DIV_CELLS division cells, 64-bit unsigned quotient.
// Depends on bptc_pkg and bptc_div_cell.
module bptc_div_chain
    import bptc_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     en,
    input  div_bus_t din,
    output div_bus_t dout
);

    div_bus_t bus [0:DIV_CELLS];

    assign bus[0] = din;

    for (genvar i = 0; i < DIV_CELLS; i++)
    begin : g_cell
        bptc_div_cell u_cell (
            .clk  (clk),
            .rst_n(rst_n),
            .en   (en),
            .din  (bus[i]),
            .dout (bus[i+1])
        );
    end

    assign dout = bus[DIV_CELLS];

endmodule

// ===== rtl/baro_temp_pressure_compensation.sv =====
// Barometric temperature and pressure compensation, fully pipelined.
// Pipeline: 10 front stages, 64 divider cells, 5 back stages. Throughput: one
// transaction per cycle; the whole pipe stalls only while a result waits on out_ready.
// Reset clears the valid bits and all calibration registers to 0. Depends on
// bptc_pkg and bptc_div_chain.
module baro_temp_pressure_compensation
    import bptc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [63:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [19:0] raw_temperature,
    input  logic [19:0] raw_pressure,
    input  logic        with_pressure,
    output logic        out_valid,
    input  logic        out_ready,
    output logic signed [31:0] temperature,
    output logic signed [31:0] fine_temperature,
    output logic [31:0] pressure,
    output logic        pressure_valid,
    output logic        divisor_zero
);

    logic [47:0] temp_coeffs_reg;
    logic [63:0] pres_a_reg;
    logic [63:0] pres_b_reg;
    logic [15:0] pres_nine_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            temp_coeffs_reg <= '0;
            pres_a_reg      <= '0;
            pres_b_reg      <= '0;
            pres_nine_reg   <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_TEMP_COEFFS: temp_coeffs_reg <= cfg_data[47:0];
                REG_PRES_A:      pres_a_reg      <= cfg_data;
                REG_PRES_B:      pres_b_reg      <= cfg_data;
                REG_PRES_NINE:   pres_nine_reg   <= cfg_data[15:0];
                default:         ;
            endcase
        end
    end

    logic [15:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
    assign t1 = temp_coeffs_reg[15:0];
    assign t2 = temp_coeffs_reg[31:16];
    assign t3 = temp_coeffs_reg[47:32];
    assign p1 = pres_a_reg[15:0];
    assign p2 = pres_a_reg[31:16];
    assign p3 = pres_a_reg[47:32];
    assign p4 = pres_a_reg[63:48];
    assign p5 = pres_b_reg[15:0];
    assign p6 = pres_b_reg[31:16];
    assign p7 = pres_b_reg[47:32];
    assign p8 = pres_b_reg[63:48];
    assign p9 = pres_nine_reg;

    logic en;
    logic out_v_reg;
    assign en       = !out_v_reg || out_ready;
    assign in_ready = en;

    // valid bits of front stages 1..10 and back stages 11..14
    logic [10:1] fv_reg;
    logic [14:11] bv_reg;
    side_t sd_reg [1:10];
    side_t bsd_reg [11:14];

    // front datapath registers
    logic [31:0] s1_m1_reg, s1_dd_reg;
    logic [31:0] s2_v1_reg, s2_m3_reg;
    logic [32:0] s4_x1_reg;
    logic [63:0] s5_xx_reg;
    logic [48:0] s5_x1p5_reg, s5_x1p2_reg, s6_x1p5_reg, s6_x1p2_reg;
    logic [63:0] s6_a6_reg, s6_a3_reg;
    logic [63:0] s7_x2_reg, s7_x1n_reg;
    logic [63:0] s8_m_reg, s8_pd_reg;
    logic [63:0] s9_den_reg, s9_num_reg;
    logic [63:0] s10_an_reg, s10_ad_reg;

    logic [31:0] a_next, d_next, m1_next, fine_next, tm_next, temp_next;
    logic [32:0] x1_next;
    logic [65:0] xx_full;
    logic [48:0] x1p5_next, x1p2_next;
    logic [63:0] x2_next, x1n_next, pd_next, den_next;
    logic [20:0] dn_next;
    logic        dz_next;
    side_t       side1_next, side4_next, side10_next;

    always_comb
    begin
        a_next  = 32'(raw_temperature >> 3) - {15'd0, t1, 1'b0};
        d_next  = 32'(raw_temperature >> 4) - {16'd0, t1};
        m1_next = mul_lo32(a_next, t2);
        side1_next      = '0;
        side1_next.praw = raw_pressure;
        side1_next.want = with_pressure;

        fine_next = s2_v1_reg + 32'($signed(s2_m3_reg) >>> 14);
        tm_next   = sd_reg[3].fine * 32'd5 + 32'd128;
        temp_next = 32'($signed(tm_next) >>> 8);
        x1_next   = $signed({sd_reg[3].fine[31], sd_reg[3].fine}) - FINE_OFFSET;
        side4_next      = sd_reg[3];
        side4_next.temp = temp_next;

        xx_full   = 66'($signed(s4_x1_reg) * $signed(s4_x1_reg));
        x1p5_next = 49'($signed(s4_x1_reg) * $signed(p5));
        x1p2_next = 49'($signed(s4_x1_reg) * $signed(p2));

        x2_next  = s6_a6_reg + ({{15{s6_x1p5_reg[48]}}, s6_x1p5_reg} << 17)
                 + ({{48{p4[15]}}, p4} << 35);
        x1n_next = 64'($signed(s6_a3_reg) >>> 8)
                 + ({{15{s6_x1p2_reg[48]}}, s6_x1p2_reg} << 12);

        dn_next = PRES_BASE - {1'b0, sd_reg[7].praw};
        pd_next = ({43'd0, dn_next} << 31) - s7_x2_reg;

        den_next = 64'($signed(s8_m_reg) >>> 33);

        dz_next = sd_reg[9].want && (s9_den_reg == 64'd0);
        side10_next     = sd_reg[9];
        side10_next.dz  = dz_next;
        side10_next.neg = s9_num_reg[63] ^ s9_den_reg[63];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fv_reg <= '0;
        end
        else if (en)
        begin
            fv_reg <= {fv_reg[9:1], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sd_reg[1]   <= side1_next;
            s1_m1_reg   <= m1_next;
            s1_dd_reg   <= d_next * d_next;

            sd_reg[2]   <= sd_reg[1];
            s2_v1_reg   <= 32'($signed(s1_m1_reg) >>> 11);
            s2_m3_reg   <= mul_lo32(32'($signed(s1_dd_reg) >>> 12), t3);

            sd_reg[3]      <= sd_reg[2];
            sd_reg[3].fine <= fine_next;

            sd_reg[4]   <= side4_next;
            s4_x1_reg   <= x1_next;

            sd_reg[5]   <= sd_reg[4];
            s5_xx_reg   <= xx_full[63:0];
            s5_x1p5_reg <= x1p5_next;
            s5_x1p2_reg <= x1p2_next;

            sd_reg[6]   <= sd_reg[5];
            s6_a6_reg   <= mul_lo64(s5_xx_reg, {p6[15], p6});
            s6_a3_reg   <= mul_lo64(s5_xx_reg, {p3[15], p3});
            s6_x1p5_reg <= s5_x1p5_reg;
            s6_x1p2_reg <= s5_x1p2_reg;

            sd_reg[7]   <= sd_reg[6];
            s7_x2_reg   <= x2_next;
            s7_x1n_reg  <= x1n_next;

            sd_reg[8]   <= sd_reg[7];
            s8_m_reg    <= mul_lo64(s7_x1n_reg + X1_BIAS, {1'b0, p1});
            s8_pd_reg   <= pd_next;

            sd_reg[9]   <= sd_reg[8];
            s9_den_reg  <= den_next;
            s9_num_reg  <= s8_pd_reg * PRES_SCALE;

            sd_reg[10]  <= side10_next;
            s10_an_reg  <= s9_num_reg[63] ? (64'd0 - s9_num_reg) : s9_num_reg;
            s10_ad_reg  <= s9_den_reg[63] ? (64'd0 - s9_den_reg) : s9_den_reg;
        end
    end

    div_bus_t div_in, div_out;

    always_comb
    begin
        div_in      = '0;
        div_in.v    = fv_reg[10];
        div_in.num  = s10_an_reg;
        div_in.den  = s10_ad_reg;
        div_in.side = sd_reg[10];
    end

    bptc_div_chain u_div (
        .clk  (clk),
        .rst_n(rst_n),
        .en   (en),
        .din  (div_in),
        .dout (div_out)
    );

    // back datapath
    logic [63:0] s11_p_reg;
    logic [63:0] s12_q13_reg, s12_c1_reg, s12_y2p_reg, s12_p_reg;
    logic [63:0] s13_ll_reg, s13_y2p_reg, s13_p_reg;
    logic [31:0] s13_cr_reg, s13_dr_reg;
    logic [63:0] s14_sum_reg;
    logic [63:0] q13_next, prod_next, pv_next;
    logic [31:0] cross_sum;

    always_comb
    begin
        q13_next  = 64'($signed(s11_p_reg) >>> 13);
        cross_sum = s13_cr_reg + s13_dr_reg;
        prod_next = s13_ll_reg + {cross_sum, 32'd0};
        pv_next   = 64'($signed(s14_sum_reg) >>> 8) + ({{48{p7[15]}}, p7} << 4);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bv_reg    <= '0;
            out_v_reg <= 1'b0;
        end
        else if (en)
        begin
            bv_reg    <= {bv_reg[13:11], div_out.v};
            out_v_reg <= bv_reg[14];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            bsd_reg[11] <= div_out.side;
            s11_p_reg   <= div_out.side.neg ? (64'd0 - div_out.num) : div_out.num;

            bsd_reg[12] <= bsd_reg[11];
            s12_q13_reg <= q13_next;
            s12_c1_reg  <= mul_lo64(q13_next, {p9[15], p9});
            s12_y2p_reg <= mul_lo64(s11_p_reg, {p8[15], p8});
            s12_p_reg   <= s11_p_reg;

            bsd_reg[13] <= bsd_reg[12];
            s13_ll_reg  <= {32'd0, s12_c1_reg[31:0]} * {32'd0, s12_q13_reg[31:0]};
            s13_cr_reg  <= s12_c1_reg[31:0] * s12_q13_reg[63:32];
            s13_dr_reg  <= s12_c1_reg[63:32] * s12_q13_reg[31:0];
            s13_y2p_reg <= s12_y2p_reg;
            s13_p_reg   <= s12_p_reg;

            bsd_reg[14] <= bsd_reg[13];
            s14_sum_reg <= s13_p_reg + 64'($signed(prod_next) >>> 25)
                         + 64'($signed(s13_y2p_reg) >>> 19);

            temperature      <= bsd_reg[14].temp;
            fine_temperature <= bsd_reg[14].fine;
            pressure_valid   <= bsd_reg[14].want && !bsd_reg[14].dz;
            divisor_zero     <= bsd_reg[14].dz;
            pressure         <= (bsd_reg[14].want && !bsd_reg[14].dz) ? pv_next[31:0] : 32'd0;
        end
    end

    assign out_valid = out_v_reg;

    a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(pressure_valid && divisor_zero))
        else $error("pressure_valid and divisor_zero both set");

    a_zero_pressure: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !pressure_valid |-> pressure == 32'd0)
        else $error("pressure not zero without a valid result");

    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> fv_reg[1])
        else $error("accepted transaction missing in first stage");

endmodule
